### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

### hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and codes for the point to segment distance engine.
// ----------------------------------------------------------------------------
package psd_pkg;
	localparam logic [1:0] REG_DEGEN    = 2'd0;
	localparam logic [1:0] REG_BEFORE   = 2'd1;
	localparam logic [1:0] REG_PAST     = 2'd2;
	localparam logic [1:0] REG_INTERIOR = 2'd3;
endpackage

### hw/rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Pipelined front end: forms D, L and K, classifies, runs the restoring
// divide one quotient bit per stage, producing t (at most one for interior items).
// ----------------------------------------------------------------------------
module psd_front #(
	parameter int CW = 24,
	parameter int TF = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [CW-1:0] sx,
	input  logic signed [CW-1:0] sy,
	input  logic signed [CW-1:0] ex,
	input  logic signed [CW-1:0] ey,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	output logic                 o_vld,
	output logic signed [CW-1:0] o_sx,
	output logic signed [CW-1:0] o_sy,
	output logic signed [CW-1:0] o_ex,
	output logic signed [CW-1:0] o_ey,
	output logic signed [CW-1:0] o_px,
	output logic signed [CW-1:0] o_py,
	output logic [1:0]           o_region,
	output logic [TF:0]          o_t
);
	localparam int LW = 2*CW + 3;
	localparam int NS = TF + 1;

	logic                 v_s1;
	logic signed [CW-1:0] sx_s1, sy_s1, ex_s1, ey_s1, px_s1, py_s1;
	logic signed [CW:0]   dx_s1, dy_s1, ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		sx_s1 <= sx; sy_s1 <= sy; ex_s1 <= ex; ey_s1 <= ey; px_s1 <= px; py_s1 <= py;
		dx_s1 <= (CW+1)'(ex) - (CW+1)'(sx);
		dy_s1 <= (CW+1)'(ey) - (CW+1)'(sy);
		ax_s1 <= (CW+1)'(px) - (CW+1)'(sx);
		ay_s1 <= (CW+1)'(py) - (CW+1)'(sy);
	end

	logic                 v_s2;
	logic signed [LW-1:0] l_s2, k_s2;
	logic signed [CW-1:0] sx_s2, sy_s2, ex_s2, ey_s2, px_s2, py_s2;
	logic signed [2*CW+1:0] mxx, myy, mkx, mky;
	logic signed [2*CW+1:0] pxx_s2, pyy_s2, pkx_s2, pky_s2;

	assign mxx = dx_s1 * dx_s1;
	assign myy = dy_s1 * dy_s1;
	assign mkx = ax_s1 * dx_s1;
	assign mky = ay_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		pxx_s2 <= mxx; pyy_s2 <= myy; pkx_s2 <= mkx; pky_s2 <= mky;
		sx_s2 <= sx_s1; sy_s2 <= sy_s1; ex_s2 <= ex_s1; ey_s2 <= ey_s1;
		px_s2 <= px_s1; py_s2 <= py_s1;
	end
	assign l_s2 = LW'(pxx_s2) + LW'(pyy_s2);
	assign k_s2 = LW'(pkx_s2) + LW'(pky_s2);

	// divide pipeline
	logic                 v_d [NS+1];
	logic [1:0]           r_d [NS+1];
	logic [LW-1:0]        rem_d [NS+1];
	logic [LW-1:0]        den_d [NS+1];
	logic [TF:0]          q_d [NS+1];
	logic signed [CW-1:0] c_d [NS+1][6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d[0] <= 1'b0;
		else v_d[0] <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (l_s2 == '0) r_d[0] <= psd_pkg::REG_DEGEN;
		else if (k_s2 < 0) r_d[0] <= psd_pkg::REG_BEFORE;
		else if (k_s2 > l_s2) r_d[0] <= psd_pkg::REG_PAST;
		else r_d[0] <= psd_pkg::REG_INTERIOR;
		rem_d[0] <= k_s2;
		den_d[0] <= l_s2;
		q_d[0] <= '0;
		c_d[0][0] <= sx_s2; c_d[0][1] <= sy_s2; c_d[0][2] <= ex_s2;
		c_d[0][3] <= ey_s2; c_d[0][4] <= px_s2; c_d[0][5] <= py_s2;
	end

	// stage 0 is the integer bit (rem == L), then TF fraction bits
	for (genvar i = 0; i < NS; i++) begin : g_div
		logic [LW:0] sh;
		logic        ge;
		assign sh = (i == 0) ? {1'b0, rem_d[i]} : {rem_d[i], 1'b0};
		assign ge = sh >= {1'b0, den_d[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else v_d[i+1] <= v_d[i];
		end
		always_ff @(posedge clk) begin
			r_d[i+1] <= r_d[i];
			den_d[i+1] <= den_d[i];
			c_d[i+1] <= c_d[i];
			rem_d[i+1] <= ge ? LW'(sh - {1'b0, den_d[i]}) : LW'(sh);
			q_d[i+1] <= {q_d[i][TF-1:0], ge};
		end
	end

	assign o_vld = v_d[NS];
	assign o_region = r_d[NS];
	assign o_t = q_d[NS];
	assign o_sx = c_d[NS][0];
	assign o_sy = c_d[NS][1];
	assign o_ex = c_d[NS][2];
	assign o_ey = c_d[NS][3];
	assign o_px = c_d[NS][4];
	assign o_py = c_d[NS][5];
endmodule

### hw/rtl/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Back end: scales D by t with rounding, picks the closest point, squares
// the offset and takes a pipelined floor square root, one bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module psd_back #(
	parameter int CW = 24,
	parameter int TF = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [CW-1:0] sx,
	input  logic signed [CW-1:0] sy,
	input  logic signed [CW-1:0] ex,
	input  logic signed [CW-1:0] ey,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	input  logic [1:0]           region_i,
	input  logic [TF:0]          t,
	output logic                 o_vld,
	output logic [CW:0]          o_dist,
	output logic signed [CW-1:0] o_qx,
	output logic signed [CW-1:0] o_qy,
	output logic [1:0]           o_region
);
	localparam int PW = CW + TF + 1;
	localparam int SW = 2*CW + 4;
	localparam int RB = CW + 2;

	// stage 1: magnitude times t
	logic                 v_s1, nx_s1, ny_s1;
	logic [PW-1:0]        mx_s1, my_s1;
	logic signed [CW-1:0] sx_s1, sy_s1, ex_s1, ey_s1, px_s1, py_s1;
	logic [1:0]           r_s1;
	logic signed [CW:0]   dxw, dyw;
	logic [CW:0]          magx, magy;

	assign dxw = (CW+1)'(ex) - (CW+1)'(sx);
	assign dyw = (CW+1)'(ey) - (CW+1)'(sy);
	assign magx = dxw[CW] ? (CW+1)'(-dxw) : dxw;
	assign magy = dyw[CW] ? (CW+1)'(-dyw) : dyw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		mx_s1 <= PW'(magx) * PW'(t);
		my_s1 <= PW'(magy) * PW'(t);
		nx_s1 <= dxw[CW];
		ny_s1 <= dyw[CW];
		sx_s1 <= sx; sy_s1 <= sy; ex_s1 <= ex; ey_s1 <= ey; px_s1 <= px; py_s1 <= py;
		r_s1 <= region_i;
	end

	// stage 2: round, select closest
	logic [PW-1:0]        rx, ry;
	logic signed [CW:0]   ix, iy;
	logic                 v_s2;
	logic signed [CW-1:0] qx_s2, qy_s2, px_s2, py_s2;
	logic [1:0]           r_s2;

	assign rx = (mx_s1 + (PW'(1) << (TF-1))) >> TF;
	assign ry = (my_s1 + (PW'(1) << (TF-1))) >> TF;
	assign ix = nx_s1 ? (CW+1)'(sx_s1) - (CW+1)'(rx) : (CW+1)'(sx_s1) + (CW+1)'(rx);
	assign iy = ny_s1 ? (CW+1)'(sy_s1) - (CW+1)'(ry) : (CW+1)'(sy_s1) + (CW+1)'(ry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		case (r_s1)
			psd_pkg::REG_PAST: begin
				qx_s2 <= ex_s1; qy_s2 <= ey_s1;
			end
			psd_pkg::REG_INTERIOR: begin
				qx_s2 <= CW'(ix); qy_s2 <= CW'(iy);
			end
			default: begin
				qx_s2 <= sx_s1; qy_s2 <= sy_s1;
			end
		endcase
		px_s2 <= px_s1; py_s2 <= py_s1; r_s2 <= r_s1;
	end

	// stage 3: squares
	logic                   v_s3;
	logic signed [CW:0]     ox, oy;
	logic [2*CW+1:0]        sqx_s3, sqy_s3;
	logic signed [CW-1:0]   qx_s3, qy_s3;
	logic [1:0]             r_s3;
	assign ox = (CW+1)'(px_s2) - (CW+1)'(qx_s2);
	assign oy = (CW+1)'(py_s2) - (CW+1)'(qy_s2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		sqx_s3 <= (2*CW+2)'(ox * ox);
		sqy_s3 <= (2*CW+2)'(oy * oy);
		qx_s3 <= qx_s2; qy_s3 <= qy_s2; r_s3 <= r_s2;
	end

	// square root pipeline, one result bit per stage, msb first
	logic                 v_r [RB+1];
	logic [SW-1:0]        op_r [RB+1];
	logic [RB-1:0]        q_r [RB+1];
	logic signed [CW-1:0] x_r [RB+1];
	logic signed [CW-1:0] y_r [RB+1];
	logic [1:0]           g_r [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_r[0] <= 1'b0;
		else v_r[0] <= v_s3;
	end
	always_ff @(posedge clk) begin
		op_r[0] <= SW'(sqx_s3) + SW'(sqy_s3);
		q_r[0] <= '0;
		x_r[0] <= qx_s3; y_r[0] <= qy_s3; g_r[0] <= r_s3;
	end

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		localparam int B = RB - 1 - i;
		logic [SW-1:0] trial;
		assign trial = (SW'(q_r[i]) << (B + 1)) + (SW'(1) << (2*B));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r[i+1] <= 1'b0;
			else v_r[i+1] <= v_r[i];
		end
		always_ff @(posedge clk) begin
			if (op_r[i] >= trial) begin
				op_r[i+1] <= op_r[i] - trial;
				q_r[i+1] <= q_r[i] | (RB'(1) << B);
			end else begin
				op_r[i+1] <= op_r[i];
				q_r[i+1] <= q_r[i];
			end
			x_r[i+1] <= x_r[i]; y_r[i+1] <= y_r[i]; g_r[i+1] <= g_r[i];
		end
	end

	assign o_vld = v_r[RB];
	assign o_dist = (CW+1)'(q_r[RB]);
	assign o_qx = x_r[RB];
	assign o_qy = y_r[RB];
	assign o_region = g_r[RB];

	`ASSERT_IMPL(a_vld_chain, v_s1 |-> ##4 v_r[1], "valid lost in back pipe")
	`ASSERT_NEVER(a_sqrt_rem, v_r[RB] && (op_r[RB] > (SW'(q_r[RB]) << 1)), "sqrt remainder")
	`ASSERT_IMPL(a_degen_q, v_s2 && r_s2 == psd_pkg::REG_DEGEN |=> qx_s3 == $past(qx_s2), "hold")
endmodule

### hw/rtl/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Closest point on a segment and floor Euclidean distance, pipelined.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, set by the fully pipelined
// divide and square root bit stages.
// Results appear on done for one cycle; the receiver cannot stall.
// Reset clears all valid flags; payload registers are not reset.
`include "assert_macros.svh"
module point_segment_distance #(
	parameter int COORD_BITS  = 24,
	parameter int FRAC_BITS   = 8,
	parameter int T_FRAC_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         done,
	output logic [COORD_BITS:0]          distance,
	output logic signed [COORD_BITS-1:0] closest_x,
	output logic signed [COORD_BITS-1:0] closest_y,
	output logic [1:0]                   region
);
	localparam int CW = COORD_BITS + 0 * FRAC_BITS;
	localparam int TF = T_FRAC_BITS;

	logic                 f_vld;
	logic signed [CW-1:0] f_sx, f_sy, f_ex, f_ey, f_px, f_py;
	logic [1:0]           f_reg;
	logic [TF:0]          f_t;

	assign busy = 1'b0;

	psd_front #(.CW(CW), .TF(TF)) u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy),
		.sx(seg_start_x), .sy(seg_start_y), .ex(seg_end_x), .ey(seg_end_y),
		.px(point_x), .py(point_y),
		.o_vld(f_vld), .o_sx(f_sx), .o_sy(f_sy), .o_ex(f_ex), .o_ey(f_ey),
		.o_px(f_px), .o_py(f_py), .o_region(f_reg), .o_t(f_t)
	);

	psd_back #(.CW(CW), .TF(TF)) u_back (
		.clk(clk), .arst_n(arst_n), .in_vld(f_vld),
		.sx(f_sx), .sy(f_sy), .ex(f_ex), .ey(f_ey), .px(f_px), .py(f_py),
		.region_i(f_reg), .t(f_t),
		.o_vld(done), .o_dist(distance), .o_qx(closest_x), .o_qy(closest_y),
		.o_region(region)
	);

	`ASSERT_NEVER(a_busy_low, busy, "busy asserted")
	`ASSERT_IMPL(a_t_clamp, f_vld && f_reg == psd_pkg::REG_INTERIOR |-> f_t <= ((TF+1)'(1) << TF), "t over one")
	`ASSERT_NEVER(a_region_known, done && $isunknown(region), "region unknown")
endmodule

### tb/sv/tb_point_segment_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_segment_distance
// Self-checking bench: drives segment/point items in random bursts, predicts
// closest point, distance and region with exact integer math, and compares
// each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_point_segment_distance;
	localparam int CB = 24;
	localparam int TF = 24;
	localparam int LATENCY = TF + CB + 10;

	typedef struct packed {
		logic [CB:0]          dst;
		logic signed [CB-1:0] qx;
		logic signed [CB-1:0] qy;
		logic [1:0]           reg_code;
	} answer_t;

	logic clk, arst_n, start;
	logic busy, done;
	logic signed [CB-1:0] sx, sy, ex, ey, px, py;
	logic [CB:0] distance;
	logic signed [CB-1:0] closest_x, closest_y;
	logic [1:0] region;

	answer_t pending[$];
	int errors = 0;
	int burst_left = 0;

	point_segment_distance dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seg_start_x(sx), .seg_start_y(sy), .seg_end_x(ex), .seg_end_y(ey),
		.point_x(px), .point_y(py), .done(done), .distance(distance),
		.closest_x(closest_x), .closest_y(closest_y), .region(region)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			b = r | (64'd1 << i);
			if (b * b <= n)
				r = b;
		end
		return r;
	endfunction

	function automatic longint round_scale(longint d, longint unsigned t);
		longint unsigned mag, r;
		mag = (d < 0) ? -d : d;
		r = (mag * t + (64'd1 << (TF - 1))) >> TF;
		return (d < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic answer_t project(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		answer_t a;
		longint dx, dy, dot, qx, qy, ddx, ddy;
		longint unsigned len, rem, t;
		dx = bx - ax;
		dy = by - ay;
		len = dx * dx + dy * dy;
		dot = (cx - ax) * dx + (cy - ay) * dy;
		if (len == 0) begin
			qx = ax; qy = ay; a.reg_code = psd_pkg::REG_DEGEN;
		end else if (dot < 0) begin
			qx = ax; qy = ay; a.reg_code = psd_pkg::REG_BEFORE;
		end else if ($unsigned(dot) > len) begin
			qx = bx; qy = by; a.reg_code = psd_pkg::REG_PAST;
		end else begin
			rem = dot;
			t = 0;
			if (rem == len) begin
				t = 1;
				rem = 0;
			end
			for (int i = 0; i < TF; i++) begin
				rem = rem << 1;
				t = t << 1;
				if (rem >= len) begin
					rem -= len;
					t |= 1;
				end
			end
			qx = ax + round_scale(dx, t);
			qy = ay + round_scale(dy, t);
			a.reg_code = psd_pkg::REG_INTERIOR;
		end
		ddx = cx - qx;
		ddy = cy - qy;
		a.dst = (CB+1)'(isqrt(ddx * ddx + ddy * ddy));
		a.qx = CB'(qx);
		a.qy = CB'(qy);
		return a;
	endfunction

	task automatic send_item(longint a, b, c, d, e, f);
		logic signed [CB-1:0] va, vb, vc, vd, ve, vf;
		int gap;
		va = CB'(a); vb = CB'(b); vc = CB'(c);
		vd = CB'(d); ve = CB'(e); vf = CB'(f);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		sx <= va; sy <= vb; ex <= vc; ey <= vd; px <= ve; py <= vf;
		start <= 1'b1;
		pending.push_back(project(va, vb, vc, vd, ve, vf));
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$display("%t: unexpected result dist=%0d", $time, distance);
				errors++;
			end else begin
				exp_a = pending.pop_front();
				if (distance !== exp_a.dst) begin
					$display("%t: distance exp %0d got %0d", $time, exp_a.dst, distance);
					errors++;
				end
				if (closest_x !== exp_a.qx) begin
					$display("%t: closest_x exp %0d got %0d", $time, exp_a.qx, closest_x);
					errors++;
				end
				if (closest_y !== exp_a.qy) begin
					$display("%t: closest_y exp %0d got %0d", $time, exp_a.qy, closest_y);
					errors++;
				end
				if (region !== exp_a.reg_code) begin
					$display("%t: region exp %0d got %0d", $time, exp_a.reg_code, region);
					errors++;
				end
			end
		end
	end

	function automatic longint rand_coord();
		case ($urandom_range(0, 5))
			0: return -longint'(8388608) + longint'($urandom_range(0, 3));
			1: return longint'(8388607) - longint'($urandom_range(0, 3));
			2: return longint'($urandom_range(0, 2047)) - 1024;
			default: return longint'($signed(CB'($urandom())));
		endcase
	endfunction

	task automatic test_directed();
		longint mn, mx;
		mn = -8388608;
		mx = 8388607;
		send_item(0, 0, 0, 0, 0, 0);
		send_item(100, 200, 100, 200, -300, 50);
		send_item(mn, mn, mn, mn, mx, mx);
		send_item(0, 0, 256, 0, -10, 5);
		send_item(0, 0, 256, 0, 300, -5);
		send_item(0, 0, 256, 0, 128, 77);
		send_item(0, 0, 256, 0, 0, 77);
		send_item(0, 0, 256, 0, 256, 77);
		send_item(0, 0, 3, 0, 1, 0);
		send_item(0, 0, 3, 3, 2, 1);
		send_item(mn, mn, mx, mx, mx, mn);
		send_item(mn, mn, mx, mx, mn, mx);
		send_item(mx, mn, mn, mx, mx, mx);
		send_item(mn, mx, mx, mn, mn, mn);
		send_item(mn, mn, mx, mn, 0, mx);
		send_item(mx, mx, mn, mn, mx, mx);
		send_item(-7, 3, 5, -9, 1, 1);
		send_item(mx, mx, mx, mx, mn, mn);
	endtask

	task automatic test_random();
		longint a, b, c, d;
		for (int i = 0; i < 1200; i++) begin
			a = rand_coord(); b = rand_coord();
			if ($urandom_range(0, 9) == 0) begin
				c = a; d = b;
			end else begin
				c = rand_coord(); d = rand_coord();
			end
			send_item(a, b, c, d, rand_coord(), rand_coord());
			if (i == 600)
				idle_until_drained();
		end
	endtask

	initial begin
		int waited;
		arst_n = 0;
		start = 0;
		sx = 0; sy = 0; ex = 0; ey = 0; px = 0; py = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_until_drained();
		test_random();
		start <= 1'b0;
		waited = 0;
		while (pending.size() != 0 && waited < 20 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### point_segment_distance.f
+incdir+hw/rtl
hw/rtl/psd_pkg.sv
hw/rtl/psd_front.sv
hw/rtl/psd_back.sv
hw/rtl/point_segment_distance.sv
tb/sv/tb_point_segment_distance.sv
